// ===== sv/two_level_bitmap_block_allocator_unit_defines.svh =====
// assertion macros shared by the allocator checker
// each macro expects clk and arst_n in scope
`ifndef TWO_LEVEL_BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define TWO_LEVEL_BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TLBA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlba check failed");

// next-cycle implication, disabled in reset
`define TLBA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlba check failed");

`endif

// ===== sv/tlba_pkg.sv =====
// types and constants of the two-level bitmap block allocator
// no dependencies
package tlba_pkg;

	localparam int OP_W    = 2;
	localparam int ID_W    = 12;
	localparam int CNT_W   = 7;
	localparam int ST_W    = 2;
	localparam int BIT_W   = 6;
	localparam int CHAIN_W = 6;
	localparam int WORD_W  = 64;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_MARK    = 2'd2;

	localparam logic [ST_W-1:0] ST_ALLOC   = 2'd0;
	localparam logic [ST_W-1:0] ST_DONE    = 2'd1;
	localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;
	localparam logic [ST_W-1:0] ST_BADID   = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_GRANT,
		S_MODIFY
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd;
		logic grant;
		logic modify;
		logic emit_bad;
		logic emit_nospace;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_alloc;
		logic is_relmark;
		logic rem_zero;
		logic id_bad;
		logic short_space;
		logic burst_done;
		logic slot_free;
	} sts_t;

endpackage

// ===== sv/tlba_ctrl.sv =====
// allocator sequencer: decodes an item and steps read / grant / modify
// depends on tlba_pkg
module tlba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tlba_pkg::sts_t sts,
	output tlba_pkg::cmd_t cmd
);

	tlba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			tlba_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = tlba_pkg::S_DECODE;
				end
			end
			tlba_pkg::S_DECODE: begin
				if (sts.is_alloc) begin
					if (sts.rem_zero) begin
						state_d = tlba_pkg::S_IDLE;
					end else if (sts.short_space) begin
						if (sts.slot_free) begin
							cmd.emit_nospace = 1'b1;
							state_d          = tlba_pkg::S_IDLE;
						end
					end else begin
						state_d = tlba_pkg::S_READ;
					end
				end else if (sts.is_relmark) begin
					if (sts.id_bad) begin
						if (sts.slot_free) begin
							cmd.emit_bad = 1'b1;
							state_d      = tlba_pkg::S_IDLE;
						end
					end else begin
						state_d = tlba_pkg::S_READ;
					end
				end else begin
					state_d = tlba_pkg::S_IDLE;
				end
			end
			tlba_pkg::S_READ: begin
				cmd.rd  = 1'b1;
				state_d = sts.is_alloc ? tlba_pkg::S_GRANT : tlba_pkg::S_MODIFY;
			end
			tlba_pkg::S_GRANT: begin
				if (sts.slot_free) begin
					cmd.grant = 1'b1;
					state_d   = sts.burst_done ? tlba_pkg::S_IDLE : tlba_pkg::S_READ;
				end
			end
			tlba_pkg::S_MODIFY: begin
				if (sts.slot_free) begin
					cmd.modify = 1'b1;
					state_d    = tlba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tlba_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/tlba_dp.sv =====
// allocator datapath: chain bitmap memory, full summary, free counter,
// chain and bit priority encoders and the result register; depends on tlba_pkg
module tlba_dp #(
	parameter int NUM_CHAINS = 64,
	parameter int MAX_BURST  = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlba_pkg::cmd_t               cmd,
	output tlba_pkg::sts_t               sts,
	input  logic [tlba_pkg::OP_W-1:0]    operation,
	input  logic [tlba_pkg::ID_W-1:0]    block_id,
	input  logic [tlba_pkg::CNT_W-1:0]   count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tlba_pkg::ID_W-1:0]    granted_block,
	output logic [tlba_pkg::ST_W-1:0]    status,
	output logic                         last
);

	localparam int AW     = (NUM_CHAINS > 1) ? $clog2(NUM_CHAINS) : 1;
	localparam int FREE_W = $clog2((NUM_CHAINS - 1) * tlba_pkg::WORD_W + 1);
	localparam int CMP_W  = tlba_pkg::ID_W + 1;

	// input item
	logic [tlba_pkg::OP_W-1:0]  op_q;
	logic [tlba_pkg::ID_W-1:0]  id_q;
	logic [tlba_pkg::CNT_W-1:0] rem_q;

	// bitmap store, entries read as zero until first written
	logic [tlba_pkg::WORD_W-1:0] mem [NUM_CHAINS];
	logic [NUM_CHAINS-1:0]       vld_q;
	logic [NUM_CHAINS-1:0]       summary_q;
	logic [FREE_W-1:0]           free_q;

	logic [AW-1:0]               rd_chain_s1;
	logic [tlba_pkg::WORD_W-1:0] rd_data_s1;
	logic                        rd_vld_s1;

	logic                        out_valid_q;
	logic [tlba_pkg::ID_W-1:0]   granted_block_q;
	logic [tlba_pkg::ST_W-1:0]   status_q;
	logic                        last_q;

	logic [tlba_pkg::CHAIN_W-1:0] id_chain;
	logic [tlba_pkg::BIT_W-1:0]   id_bit;
	logic [AW-1:0]                enc_chain;
	logic [AW-1:0]                rd_addr;
	logic [tlba_pkg::BIT_W-1:0]   enc_bit;
	logic [tlba_pkg::WORD_W-1:0]  word;
	logic [tlba_pkg::WORD_W-1:0]  gmask;
	logic [tlba_pkg::WORD_W-1:0]  mmask;
	logic [tlba_pkg::WORD_W-1:0]  new_word;
	logic [tlba_pkg::CNT_W-1:0]   cnt_sat;
	logic                         wr_en;
	logic                         out_load;
	logic                         free_inc;
	logic                         free_dec;

	assign id_chain = id_q[tlba_pkg::ID_W-1:tlba_pkg::BIT_W];
	assign id_bit   = id_q[tlba_pkg::BIT_W-1:0];
	assign cnt_sat  = (count > tlba_pkg::CNT_W'(MAX_BURST)) ?
		tlba_pkg::CNT_W'(MAX_BURST) : count;

	// lowest chain that is not full, chain 0 excluded
	always_comb begin
		enc_chain = '0;
		for (int i = NUM_CHAINS - 1; i >= 1; i--) begin
			if (!summary_q[i]) begin
				enc_chain = AW'(i);
			end
		end
	end

	assign word = rd_vld_s1 ? rd_data_s1 : '0;

	// lowest free block of the fetched chain
	always_comb begin
		enc_bit = '0;
		for (int i = tlba_pkg::WORD_W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				enc_bit = tlba_pkg::BIT_W'(i);
			end
		end
	end

	assign rd_addr  = (op_q == tlba_pkg::OP_ALLOC) ? enc_chain : id_chain[AW-1:0];
	assign gmask    = tlba_pkg::WORD_W'(1) << enc_bit;
	assign mmask    = tlba_pkg::WORD_W'(1) << id_bit;
	assign wr_en    = cmd.grant | cmd.modify;
	assign out_load = cmd.grant | cmd.modify | cmd.emit_bad | cmd.emit_nospace;

	always_comb begin
		if (cmd.grant) begin
			new_word = word | gmask;
		end else if (op_q == tlba_pkg::OP_RELEASE) begin
			new_word = word & ~mmask;
		end else begin
			new_word = word | mmask;
		end
	end

	assign free_inc = cmd.modify & (op_q == tlba_pkg::OP_RELEASE) & word[id_bit];
	assign free_dec = cmd.grant | (cmd.modify & (op_q == tlba_pkg::OP_MARK) & ~word[id_bit]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			id_q <= block_id;
		end
		if (cmd.rd) begin
			rd_chain_s1 <= rd_addr;
			rd_data_s1  <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[rd_chain_s1] <= new_word;
		end
		if (out_load) begin
			granted_block_q <= cmd.grant ?
				{tlba_pkg::CHAIN_W'(rd_chain_s1), enc_bit} : '0;
			last_q          <= cmd.grant ? (rem_q == tlba_pkg::CNT_W'(1)) : 1'b1;
			if (cmd.grant) begin
				status_q <= tlba_pkg::ST_ALLOC;
			end else if (cmd.modify) begin
				status_q <= tlba_pkg::ST_DONE;
			end else if (cmd.emit_bad) begin
				status_q <= tlba_pkg::ST_BADID;
			end else begin
				status_q <= tlba_pkg::ST_NOSPACE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			vld_q       <= '0;
			summary_q   <= '0;
			free_q      <= FREE_W'((NUM_CHAINS - 1) * tlba_pkg::WORD_W);
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				rem_q <= cnt_sat;
			end else if (cmd.grant) begin
				rem_q <= rem_q - tlba_pkg::CNT_W'(1);
			end
			if (cmd.rd) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[rd_chain_s1]     <= 1'b1;
				summary_q[rd_chain_s1] <= &new_word;
			end
			if (free_inc) begin
				free_q <= free_q + FREE_W'(1);
			end else if (free_dec) begin
				free_q <= free_q - FREE_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.is_alloc    = (op_q == tlba_pkg::OP_ALLOC);
		sts.is_relmark  = (op_q == tlba_pkg::OP_RELEASE) || (op_q == tlba_pkg::OP_MARK);
		sts.rem_zero    = (rem_q == '0);
		sts.id_bad      = (id_chain == '0) ||
			((tlba_pkg::CHAIN_W + 1)'(id_chain) >= (tlba_pkg::CHAIN_W + 1)'(NUM_CHAINS));
		sts.short_space = CMP_W'(free_q) < CMP_W'(rem_q);
		sts.burst_done  = (rem_q == tlba_pkg::CNT_W'(1));
		sts.slot_free   = !out_valid_q || !out_stall;
	end

	assign out_valid     = out_valid_q;
	assign granted_block = granted_block_q;
	assign status        = status_q;
	assign last          = last_q;

endmodule

// ===== sv/two_level_bitmap_block_allocator_unit.sv =====
// two-level bitmap block allocator, top level
// depends on tlba_pkg, tlba_ctrl, tlba_dp
//  - input channel in_valid / in_stall carries operation, block_id, count;
//    a transaction completes when in_valid is high and in_stall low
//  - output channel out_valid / out_stall carries granted_block, status, last;
//    last marks the final result of one input item
//  - one item is worked at a time: in_stall stays high from acceptance until
//    the item's last result has been loaded into the output register
//  - allocate of n blocks: a decode step, then per block a bitmap read and
//    then encode and write back; the memory read port and its registered data
//    split each block into these two steps
//  - release and mark load their result after decode, read and modify; bad id
//    and out of space load theirs in decode; the next transaction is taken the
//    cycle after the last result is loaded; zero count or an unused
//    operation return to idle after decode with no result
//  - a stalled result holds in the output register; the sequencer waits
//    before producing the next one
//  - reset sets the free counter full and clears summary and per-chain valid
//    bits at once, so every block reads as free; no clearing pass is needed
module two_level_bitmap_block_allocator_unit #(
	parameter int NUM_CHAINS = 64,
	parameter int MAX_BURST  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [11:0] block_id,
	input  logic [6:0]  count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] granted_block,
	output logic [1:0]  status,
	output logic        last
);

	// command and status between sequencer and datapath
	tlba_pkg::cmd_t cmd;
	tlba_pkg::sts_t sts;

	tlba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bitmap memory, summary, free count and result register
	tlba_dp #(
		.NUM_CHAINS (NUM_CHAINS),
		.MAX_BURST  (MAX_BURST)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.block_id      (block_id),
		.count         (count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.granted_block (granted_block),
		.status        (status),
		.last          (last)
	);

endmodule

// ===== sv/tlba_checker.sv =====
// port-level checks for the allocator, bound to the top level
// depends on tlba_pkg and the defines header
`include "two_level_bitmap_block_allocator_unit_defines.svh"

module tlba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] granted_block,
	input logic [1:0]  status,
	input logic        last
);

	// stalled result holds
	`TLBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(granted_block) && $stable(status) && $stable(last))

	// one item at a time: busy right after an accepted transaction
	`TLBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// only grants carry a block number
	`TLBA_ASSERT_NOW(a_zero_block, out_valid && (status != tlba_pkg::ST_ALLOC),
		granted_block == 12'd0)

	// grants never come from the reserved chain
	`TLBA_ASSERT_NOW(a_no_chain0, out_valid && (status == tlba_pkg::ST_ALLOC),
		granted_block[11:6] != 6'd0)

	// non-grant results are always single and final
	`TLBA_ASSERT_NOW(a_single_last, out_valid && (status != tlba_pkg::ST_ALLOC), last)

endmodule

bind two_level_bitmap_block_allocator_unit tlba_checker u_tlba_checker (.*);

// ===== verif/two_level_bitmap_block_allocator_unit_tb.sv =====
// self-checking bench for the two-level bitmap block allocator
// depends on tlba_pkg and two_level_bitmap_block_allocator_unit
`timescale 1ns / 1ps

module two_level_bitmap_block_allocator_unit_tb;

	localparam int CHAIN_COUNT  = 64;
	localparam int BURST_MAX    = 64;
	localparam int RANDOM_ITEMS = 190;
	localparam int QUIET_ITEMS  = 40;
	localparam int TIGHT_ITEMS  = 45;
	localparam int TAIL_CYCLES  = 150;
	localparam int IDLE_LIMIT   = 4000;

	// operation code the block ignores
	localparam logic [tlba_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [tlba_pkg::OP_W-1:0]  op;
		logic [tlba_pkg::ID_W-1:0]  id;
		logic [tlba_pkg::CNT_W-1:0] cnt;
		logic                       drain; // sender waits until all results are back
	} alloc_req_t;

	typedef struct packed {
		logic [tlba_pkg::ID_W-1:0] blk;
		logic [tlba_pkg::ST_W-1:0] st;
		logic                      lst;
	} grant_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [tlba_pkg::OP_W-1:0]   operation = tlba_pkg::OP_ALLOC;
	logic [tlba_pkg::ID_W-1:0]   block_id = '0;
	logic [tlba_pkg::CNT_W-1:0]  count = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [tlba_pkg::ID_W-1:0]   granted_block;
	logic [tlba_pkg::ST_W-1:0]   status;
	logic                        last;

	// shadow of the allocator state
	logic [tlba_pkg::WORD_W-1:0] chain_map [CHAIN_COUNT];
	logic [tlba_pkg::WORD_W-1:0] full_map;

	alloc_req_t pending_q [$];
	grant_t     grant_q [$];
	alloc_req_t on_wire;
	grant_t     oldest;

	int  errors = 0;
	int  send_gap = 0;
	int  hold_left = 0;
	int  idle_cycles = 0;
	int  cyc = 0;
	bit  quiet_tail = 1'b0;
	bit  tx_mood = 1'b1;
	bit  rx_mood = 1'b1;

	two_level_bitmap_block_allocator_unit #(
		.NUM_CHAINS(CHAIN_COUNT),
		.MAX_BURST (BURST_MAX)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.block_id     (block_id),
		.count        (count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted_block(granted_block),
		.status       (status),
		.last         (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int c = 0; c < CHAIN_COUNT; c++)
			chain_map[c] = '0;
		full_map = '0;
	end

	// free blocks over the usable chains
	function automatic int unsigned blocks_free();
		int unsigned total;
		total = 0;
		for (int c = 1; c < CHAIN_COUNT; c++)
			total += tlba_pkg::WORD_W - $countones(chain_map[c]);
		return total;
	endfunction

	// keep the full-chain summary exact for one chain
	function automatic void sync_summary(int unsigned ch);
		full_map[ch] = &chain_map[ch];
	endfunction

	// append one expected result
	function automatic void expect_result(grant_t res);
		grant_q = {grant_q, res};
	endfunction

	// append one transaction for the sender
	function automatic void queue_req(alloc_req_t req);
		pending_q = {pending_q, req};
	endfunction

	// work out the results of one accepted transaction and update the shadow
	task automatic grant_blocks(input alloc_req_t req);
		int unsigned want;
		int unsigned ch;
		int unsigned bt;
		grant_t      res;
		case (req.op)
			tlba_pkg::OP_ALLOC: begin
				if (req.cnt != 0) begin
					want = (req.cnt > BURST_MAX) ? BURST_MAX : req.cnt;
					if (blocks_free() < want) begin
						res = '{blk: '0, st: tlba_pkg::ST_NOSPACE, lst: 1'b1};
						expect_result(res);
					end else begin
						while (want > 0) begin
							// lowest chain not marked full, then its lowest free bit
							ch = 1;
							while (full_map[ch])
								ch++;
							bt = 0;
							while (chain_map[ch][bt])
								bt++;
							chain_map[ch][bt] = 1'b1;
							sync_summary(ch);
							want--;
							res.blk = {ch[tlba_pkg::CHAIN_W-1:0], bt[tlba_pkg::BIT_W-1:0]};
							res.st  = tlba_pkg::ST_ALLOC;
							res.lst = (want == 0);
							expect_result(res);
						end
					end
				end
			end
			tlba_pkg::OP_RELEASE, tlba_pkg::OP_MARK: begin
				ch = req.id[tlba_pkg::ID_W-1:tlba_pkg::BIT_W];
				bt = req.id[tlba_pkg::BIT_W-1:0];
				if (ch == 0 || ch >= CHAIN_COUNT) begin
					res = '{blk: '0, st: tlba_pkg::ST_BADID, lst: 1'b1};
				end else begin
					chain_map[ch][bt] = (req.op == tlba_pkg::OP_MARK);
					sync_summary(ch);
					res = '{blk: '0, st: tlba_pkg::ST_DONE, lst: 1'b1};
				end
				expect_result(res);
			end
			default: ;
		endcase
	endtask

	function automatic alloc_req_t req_of(logic [tlba_pkg::OP_W-1:0] op,
			logic [tlba_pkg::ID_W-1:0] id, logic [tlba_pkg::CNT_W-1:0] cnt, logic drain);
		alloc_req_t req;
		req = '{op: op, id: id, cnt: cnt, drain: drain};
		return req;
	endfunction

	// random block in a usable chain
	function automatic logic [tlba_pkg::ID_W-1:0] any_block();
		return {tlba_pkg::CHAIN_W'($urandom_range(1, CHAIN_COUNT - 1)),
			tlba_pkg::BIT_W'($urandom_range(0, 63))};
	endfunction

	// a block that the shadow holds as used, if one turns up quickly
	function automatic logic [tlba_pkg::ID_W-1:0] used_block();
		logic [tlba_pkg::ID_W-1:0] id;
		id = any_block();
		for (int k = 0; k < 24; k++) begin
			if (chain_map[id[tlba_pkg::ID_W-1:tlba_pkg::BIT_W]][id[tlba_pkg::BIT_W-1:0]])
				return id;
			id = any_block();
		end
		return id;
	endfunction

	// phase 0 fills the space, phase 1 works near full, phase 2 is a loose mix
	function automatic alloc_req_t random_req(int phase, logic drain);
		int unsigned roll;
		logic [tlba_pkg::OP_W-1:0] relmark;
		roll    = $urandom_range(0, 99);
		relmark = $urandom_range(0, 1) ? tlba_pkg::OP_RELEASE : tlba_pkg::OP_MARK;
		if (roll >= 95) begin
			// ignored or empty transactions
			if ($urandom_range(0, 1))
				return req_of(OP_SPARE, tlba_pkg::ID_W'($urandom),
					tlba_pkg::CNT_W'($urandom), drain);
			return req_of(tlba_pkg::OP_ALLOC, tlba_pkg::ID_W'($urandom), '0, drain);
		end
		if (roll >= 90)
			return req_of(relmark, {{tlba_pkg::CHAIN_W{1'b0}}, tlba_pkg::BIT_W'($urandom)},
				tlba_pkg::CNT_W'($urandom), drain);
		case (phase)
			0: begin
				if (roll < 75)
					return req_of(tlba_pkg::OP_ALLOC, tlba_pkg::ID_W'($urandom),
						tlba_pkg::CNT_W'($urandom_range(48, 127)), drain);
				if (roll < 82)
					return req_of(tlba_pkg::OP_ALLOC, tlba_pkg::ID_W'($urandom),
						tlba_pkg::CNT_W'($urandom_range(1, 8)), drain);
				return req_of(relmark, any_block(), tlba_pkg::CNT_W'($urandom), drain);
			end
			1: begin
				if (roll < 40)
					return req_of(tlba_pkg::OP_ALLOC, tlba_pkg::ID_W'($urandom),
						tlba_pkg::CNT_W'($urandom_range(1, 64)), drain);
				if (roll < 75)
					return req_of(tlba_pkg::OP_RELEASE, used_block(),
						tlba_pkg::CNT_W'($urandom), drain);
				return req_of(tlba_pkg::OP_MARK, any_block(), tlba_pkg::CNT_W'($urandom),
					drain);
			end
			default: begin
				if (roll < 30)
					return req_of(tlba_pkg::OP_ALLOC, tlba_pkg::ID_W'($urandom),
						tlba_pkg::CNT_W'($urandom_range(1, 20)), drain);
				if (roll < 60)
					return req_of(relmark, tlba_pkg::ID_W'($urandom),
						tlba_pkg::CNT_W'($urandom), drain);
				return req_of(tlba_pkg::OP_RELEASE, used_block(),
					tlba_pkg::CNT_W'($urandom), drain);
			end
		endcase
	endfunction

	// sender: presents queued transactions, holds a stalled one, idles in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= tlba_pkg::OP_ALLOC;
			block_id  <= '0;
			count     <= '0;
		end else begin
			if (in_valid && !in_stall)
				grant_blocks(on_wire);
			// a stalled transaction keeps its payload untouched
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_q.size() == 0 ||
						(pending_q[0].drain && grant_q.size() != 0)) begin
					in_valid <= 1'b0;
				end else if (!quiet_tail && tx_mood && $urandom_range(0, 4) == 0) begin
					send_gap = $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else begin
					on_wire = pending_q.pop_front();
					in_valid  <= 1'b1;
					operation <= on_wire.op;
					block_id  <= on_wire.id;
					count     <= on_wire.cnt;
				end
			end
		end
	end

	// receiver: checks each result against the oldest expected one, stalls in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (grant_q.size() == 0) begin
					$display("%0t: result with nothing expected: block %0d status %0d last %0d",
						$time, granted_block, status, last);
					errors++;
				end else begin
					oldest = grant_q.pop_front();
					if (granted_block !== oldest.blk) begin
						$display("%0t: granted_block expected %0d actual %0d",
							$time, oldest.blk, granted_block);
						errors++;
					end
					if (status !== oldest.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, oldest.st, status);
						errors++;
					end
					if (last !== oldest.lst) begin
						$display("%0t: last expected %0d actual %0d",
							$time, oldest.lst, last);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!quiet_tail && rx_mood && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(0, 13);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// idling moods change now and then, giving stretches with no idling
	// watchdog counts cycles in which neither channel moves a transaction
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 128 == 0) begin
			tx_mood <= ($urandom_range(0, 2) != 0);
			rx_mood <= ($urandom_range(0, 2) != 0);
		end
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		int tight_from;
		logic drain;
		phase = 0;
		tight_from = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening
		queue_req(req_of(OP_SPARE, 12'hFFF, 7'h7F, 1'b0));              // ignored op
		queue_req(req_of(tlba_pkg::OP_ALLOC, 12'h000, 7'd0, 1'b0));     // zero count
		queue_req(req_of(tlba_pkg::OP_ALLOC, 12'h000, 7'd1, 1'b0));     // first block
		queue_req(req_of(tlba_pkg::OP_ALLOC, 12'hFFF, 7'd64, 1'b0));    // crosses a chain
		queue_req(req_of(tlba_pkg::OP_ALLOC, 12'h000, 7'd127, 1'b0));   // saturates
		queue_req(req_of(tlba_pkg::OP_ALLOC, 12'h000, 7'd65, 1'b0));    // just above burst
		queue_req(req_of(tlba_pkg::OP_RELEASE, 12'h000, 7'd0, 1'b0));   // reserved chain
		queue_req(req_of(tlba_pkg::OP_MARK, 12'h03F, 7'd0, 1'b0));      // reserved chain
		queue_req(req_of(tlba_pkg::OP_RELEASE, 12'hFFF, 7'd0, 1'b0));   // top block, free
		queue_req(req_of(tlba_pkg::OP_MARK, 12'hFFF, 7'd0, 1'b0));
		queue_req(req_of(tlba_pkg::OP_MARK, 12'hFFF, 7'd0, 1'b0));      // mark twice
		queue_req(req_of(tlba_pkg::OP_RELEASE, 12'd64, 7'd0, 1'b0));
		queue_req(req_of(tlba_pkg::OP_RELEASE, 12'd64, 7'd0, 1'b0));    // release twice
		queue_req(req_of(tlba_pkg::OP_ALLOC, 12'h000, 7'd1, 1'b0));     // reuses the hole
		queue_req(req_of(tlba_pkg::OP_RELEASE, 12'd100, 7'd0, 1'b0));   // full chain reopens
		queue_req(req_of(tlba_pkg::OP_ALLOC, 12'h000, 7'd2, 1'b0));
		queue_req(req_of(tlba_pkg::OP_MARK, 12'd600, 7'd0, 1'b0));      // marks a block in chain 9
		queue_req(req_of(tlba_pkg::OP_ALLOC, 12'h000, 7'd10, 1'b0));
		queue_req(req_of(OP_SPARE, 12'h000, 7'd0, 1'b0));
		queue_req(req_of(tlba_pkg::OP_RELEASE, 12'hFFF, 7'd0, 1'b0));
		queue_req(req_of(tlba_pkg::OP_ALLOC, 12'h555, 7'h2A, 1'b1));    // after a full drain

		// random part, generated against the current shadow state
		for (int r = 0; r < RANDOM_ITEMS; r++) begin
			while (pending_q.size() >= 2)
				@(posedge clk);
			drain = 1'b0;
			if (phase == 0 && (blocks_free() < 48 || r >= 120)) begin
				phase = 1;
				tight_from = r;
				drain = 1'b1;
			end else if (phase == 1 && r >= tight_from + TIGHT_ITEMS) begin
				phase = 2;
				drain = 1'b1;
			end
			quiet_tail = (r >= RANDOM_ITEMS - QUIET_ITEMS);
			queue_req(random_req(phase, drain));
		end

		while (pending_q.size() != 0 || in_valid)
			@(posedge clk);
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
